### design/assert_macros.svh
// Assertion macros used by the checker module of the attack mask unit.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SPAM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define SPAM_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/spam_pkg.sv
// Package of the sliding piece attack mask unit: piece codes, ray steps and
// the data record that moves down the chain of ray cells. No dependencies.
package spam_pkg;

	localparam int NUM_RAYS  = 8;
	localparam int NUM_CELLS = 7;

	typedef enum logic [1:0] {
		KIND_ROOK   = 2'd0,
		KIND_BISHOP = 2'd1,
		KIND_QUEEN  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// Rays 0..3 orthogonal (north, south, east, west), 4..7 diagonal
	// (north-east, north-west, south-west, south-east). Steps are 4-bit
	// two's complement so that leaving the board shows in bit 3.
	localparam logic [3:0] RANK_STEP [NUM_RAYS] = '{
		4'b0001, 4'b1111, 4'b0000, 4'b0000,
		4'b0001, 4'b0001, 4'b1111, 4'b1111
	};
	localparam logic [3:0] FILE_STEP [NUM_RAYS] = '{
		4'b0000, 4'b0000, 4'b0001, 4'b1111,
		4'b0001, 4'b1111, 4'b1111, 4'b0001
	};

	typedef struct packed {
		logic       alive;
		logic [2:0] rank;
		logic [2:0] file;
	} ray_t;

	typedef ray_t [NUM_RAYS-1:0] ray_set_t;

	typedef struct packed {
		ray_set_t    rays;
		logic [63:0] occ;
		logic [63:0] mask;
	} cell_data_t;

endpackage

### design/spam_cell.sv
// One cell of the ray chain: moves every live ray one square outward,
// marks the square and stops the ray on a piece or at the edge.
// Depends on spam_pkg.
module spam_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                in_valid,
	input  spam_pkg::cell_data_t in_data,
	output logic                out_valid,
	output spam_pkg::cell_data_t out_data
);
	import spam_pkg::*;

	logic       valid_q;
	cell_data_t data_q;
	cell_data_t step_data;

	// Take one step on each of the eight rays
	always_comb begin
		logic [3:0] r_nxt;
		logic [3:0] f_nxt;
		logic [5:0] sq;
		step_data = in_data;
		for (int i = 0; i < NUM_RAYS; i++) begin
			r_nxt = {1'b0, in_data.rays[i].rank} + RANK_STEP[i];
			f_nxt = {1'b0, in_data.rays[i].file} + FILE_STEP[i];
			sq    = {r_nxt[2:0], f_nxt[2:0]};
			if (in_data.rays[i].alive && !r_nxt[3] && !f_nxt[3]) begin
				step_data.mask[sq]     = 1'b1;
				step_data.rays[i].rank = r_nxt[2:0];
				step_data.rays[i].file = f_nxt[2:0];
				step_data.rays[i].alive = !in_data.occ[sq];
			end else begin
				step_data.rays[i].alive = 1'b0;
			end
		end
	end

	// Hand the item on to the next cell when the chain moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= step_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### design/sliding_piece_attack_mask_unit.sv
// Sliding piece attack mask unit. Give it a piece kind (rook, bishop or
// queen), an origin square (rank * 8 + file) and a 64-bit occupancy mask,
// and it returns the 64-bit mask of squares the piece attacks; each ray
// includes the first occupied square and stops there, an unused kind code
// gives zero. It takes one item per cycle while the output is not stalled; a
// chain of seven cells walks all eight rays one square per cell. The last
// cell is the output register; while its result waits the whole chain holds
// and s_axis_tready is low.
// Depends on spam_pkg and spam_cell.
module sliding_piece_attack_mask_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // [5:0] origin_square, [69:6] occupancy, [71:70] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // [63:0] attack_mask
);
	import spam_pkg::*;

	logic                     advance;
	logic [NUM_CELLS:0]       cell_valid;
	cell_data_t [NUM_CELLS:0] cell_data;
	cell_data_t               seed_data;
	logic [5:0]               origin;
	logic                     orth_on;
	logic                     diag_on;

	// Move the chain unless the finished item is still waiting
	assign advance       = !cell_valid[NUM_CELLS] || m_axis_tready;
	assign s_axis_tready = advance;

	// Seed every ray at the origin square; enable rays by piece kind
	assign origin  = s_axis_tdata[5:0];
	assign orth_on = (s_axis_tuser == KIND_ROOK) || (s_axis_tuser == KIND_QUEEN);
	assign diag_on = (s_axis_tuser == KIND_BISHOP) || (s_axis_tuser == KIND_QUEEN);

	always_comb begin
		seed_data.occ  = s_axis_tdata[69:6];
		seed_data.mask = '0;
		for (int i = 0; i < NUM_RAYS; i++) begin
			seed_data.rays[i].rank  = origin[5:3];
			seed_data.rays[i].file  = origin[2:0];
			seed_data.rays[i].alive = (i < NUM_RAYS / 2) ? orth_on : diag_on;
		end
	end

	assign cell_valid[0] = s_axis_tvalid;
	assign cell_data[0]  = seed_data;

	// Row of ray cells, one square of travel each
	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		spam_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.in_valid (cell_valid[c]),
			.in_data  (cell_data[c]),
			.out_valid(cell_valid[c+1]),
			.out_data (cell_data[c+1])
		);
	end

	assign m_axis_tvalid = cell_valid[NUM_CELLS];
	assign m_axis_tdata  = cell_data[NUM_CELLS].mask;

endmodule

### design/spam_chk.sv
// Port checker for the sliding piece attack mask unit, bound to the top
// level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module spam_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [71:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	logic out_stall;

	// Finished item offered but not taken
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// Chain moves exactly when the output side can take an item
	`SPAM_ASSERT(a_ready_out, clk, arst_n, s_axis_tready == !out_stall, "tready ignores stall")

	// No result shows on the edge after reset is seen
	`SPAM_ASSERT_RST(a_reset_empty, clk, !arst_n |=> !m_axis_tvalid, "result valid after reset")

	// A stalled result stays offered
	`SPAM_ASSERT(a_out_hold, clk, arst_n, out_stall |=> m_axis_tvalid, "valid dropped in stall")

	// A stalled result keeps its mask
	`SPAM_ASSERT(a_out_data, clk, arst_n, out_stall |=> $stable(m_axis_tdata), "tdata moved")

endmodule

bind sliding_piece_attack_mask_unit spam_chk u_spam_chk (.*);
